// ===== design/hpq_pkg.sv =====
// Shared types, codes and helpers for the heap priority queue.
// Depends on nothing; used by the controller, the datapath and the top level.
package hpq_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int DATA_W           = 32;
   localparam int COUNT_OUT_W      = 7;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_ROOT = -32'sd1;

   typedef struct packed {
      logic       set_status;
      logic [1:0] status_code;
      logic       ld_push;
      logic       dec_count;
      logic       rd_parent;
      logic       rd_last;
      logic       rd_children;
      logic       ld_last;
      logic       wr_hold;
      logic       wr_move_up;
      logic       wr_move_down;
      logic       respond;
   } hpq_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic count_full;
      logic pos_zero;
      logic up_wins;
      logic leaf;
      logic stop;
   } hpq_stat_type;

   function automatic logic ranks_above(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b,
                                        input logic min_mode);
      ranks_above = min_mode ? (a < b) : (a > b);
   endfunction

endpackage

// ===== design/hpq_datapath.sv =====
// Datapath of the heap priority queue: heap memory, fill count, root copy,
// moving value and position, order register and result registers. Uses hpq_pkg.
module hpq_datapath
   import hpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hpq_cmd_type              cmd,
   output hpq_stat_type             stat,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_order_mode,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_root_value,
   output logic [COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic [1:0]               rsp_status
);

   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CHILD_W = ADDR_W + 2;

   logic signed [DATA_W-1:0] heap_mem_ff [CAPACITY];
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [DATA_W-1:0] root_ff;
   logic signed [DATA_W-1:0] hold_ff, hold_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     order_mode_ff;
   logic [1:0]               status_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_root_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;
   logic                     rsp_empty_ff;
   logic [1:0]               rsp_status_ff;

   logic [ADDR_W-1:0]        parent_idx;
   logic [CHILD_W-1:0]       l_idx, r_idx, count_ext, best_idx;
   logic [ADDR_W-1:0]        addr_a, addr_b;
   logic                     rd_en, wr_en;
   logic signed [DATA_W-1:0] wr_data, best_val;
   logic                     l_wins, r_wins;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   assign parent_idx = (pos_ff - ADDR_W'(1)) >> 1;
   assign l_idx      = {1'b0, pos_ff, 1'b1};
   assign r_idx      = {1'b0, pos_ff, 1'b0} + CHILD_W'(2);
   assign count_ext  = {{(CHILD_W-CNT_W){1'b0}}, count_ff};

   always_comb begin
      l_wins   = ranks_above(rd_a_ff, hold_ff, order_mode_ff);
      best_val = l_wins ? rd_a_ff : hold_ff;
      best_idx = l_wins ? l_idx : {2'b00, pos_ff};
      r_wins   = (r_idx < count_ext) && ranks_above(rd_b_ff, best_val, order_mode_ff);
      if (r_wins) begin
         best_val = rd_b_ff;
         best_idx = r_idx;
      end
   end

   always_comb begin
      stat.count_zero = (count_ff == '0);
      stat.count_one  = (count_ff == CNT_W'(1));
      stat.count_full = (count_ff == CNT_W'(CAPACITY));
      stat.pos_zero   = (pos_ff == '0);
      stat.up_wins    = ranks_above(hold_ff, rd_a_ff, order_mode_ff);
      stat.leaf       = (l_idx >= count_ext);
      stat.stop       = !l_wins && !r_wins;
   end

   always_comb begin
      addr_a = parent_idx;
      if (cmd.rd_last) begin
         addr_a = count_ff[ADDR_W-1:0];
      end else if (cmd.rd_children) begin
         addr_a = l_idx[ADDR_W-1:0];
      end
      addr_b = r_idx[ADDR_W-1:0];
      rd_en  = cmd.rd_parent | cmd.rd_last | cmd.rd_children;
   end

   always_comb begin
      wr_en    = cmd.wr_hold | cmd.wr_move_up | cmd.wr_move_down;
      wr_data  = hold_ff;
      pos_in   = pos_ff;
      hold_in  = hold_ff;
      count_in = count_ff;
      if (cmd.wr_move_up) begin
         wr_data = rd_a_ff;
         pos_in  = parent_idx;
      end else if (cmd.wr_move_down) begin
         wr_data = best_val;
         pos_in  = best_idx[ADDR_W-1:0];
      end
      if (cmd.ld_push) begin
         hold_in  = req_value;
         pos_in   = count_ff[ADDR_W-1:0];
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.ld_last) begin
         hold_in = rd_a_ff;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[pos_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= heap_mem_ff[addr_a];
         rd_b_ff <= heap_mem_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (pos_ff == '0)) begin
         root_ff <= wr_data;
      end
      hold_ff <= hold_in;
      pos_ff  <= pos_in;
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         order_mode_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            order_mode_ff <= csr_order_mode;
         end
      end
   end

   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_root_ff   <= stat.count_zero ? EMPTY_ROOT : root_ff;
         rsp_count_ff  <= count_wide[COUNT_OUT_W-1:0];
         rsp_empty_ff  <= stat.count_zero;
         rsp_status_ff <= status_ff;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_value  = rsp_root_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && (status_ff == STATUS_FULL) |-> stat.count_full)
      else $error("full status while not full");

   a_empty_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> (rsp_root_ff == EMPTY_ROOT))
      else $error("empty beat without empty root");

   a_move_up_pos: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_move_up |-> !stat.pos_zero)
      else $error("move up from the root");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_push |=> !stat.count_zero)
      else $error("push left the queue empty");
`endif

endmodule

// ===== design/hpq_controller.sv =====
// Controller of the heap priority queue: sequences push, pop and peek
// through sift up and sift down. Uses hpq_pkg.
module hpq_controller
   import hpq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   req_command,
   output logic         busy,
   input  hpq_stat_type stat,
   output hpq_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UP_RD  = 3'd1;
   localparam logic [2:0] ST_UP_CMP = 3'd2;
   localparam logic [2:0] ST_POP_RD = 3'd3;
   localparam logic [2:0] ST_POP_LD = 3'd4;
   localparam logic [2:0] ST_DN_RD  = 3'd5;
   localparam logic [2:0] ST_DN_CMP = 3'd6;
   localparam logic [2:0] ST_RESP   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_OK;
               case (req_command)
                  CMD_PUSH: begin
                     if (stat.count_full) begin
                        cmd.status_code = STATUS_FULL;
                        state_in        = ST_RESP;
                     end else begin
                        cmd.ld_push = 1'b1;
                        state_in    = ST_UP_RD;
                     end
                  end
                  CMD_POP: begin
                     if (stat.count_zero) begin
                        cmd.status_code = STATUS_EMPTY;
                        state_in        = ST_RESP;
                     end else begin
                        cmd.dec_count = 1'b1;
                        state_in      = stat.count_one ? ST_RESP : ST_POP_RD;
                     end
                  end
                  default: begin
                     if (stat.count_zero) begin
                        cmd.status_code = STATUS_EMPTY;
                     end
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.wr_hold = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_wins) begin
               cmd.wr_move_up = 1'b1;
               state_in       = ST_UP_RD;
            end else begin
               cmd.wr_hold = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_POP_RD: begin
            cmd.rd_last = 1'b1;
            state_in    = ST_POP_LD;
         end
         ST_POP_LD: begin
            cmd.ld_last = 1'b1;
            state_in    = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (stat.leaf) begin
               cmd.wr_hold = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.rd_children = 1'b1;
               state_in        = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (stat.stop) begin
               cmd.wr_hold = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.wr_move_down = 1'b1;
               state_in         = ST_DN_RD;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== design/heap_priority_queue.sv =====
// Top level of the heap priority queue: controller and datapath joined by
// command and status structs. Uses hpq_pkg, hpq_controller and hpq_datapath.
//
//   channel   direction  handshake              payload
//   req_      in         start & !busy          req_command, req_value
//   rsp_      out        rsp_valid (strobe)     rsp_root_value, rsp_entry_count,
//                                               rsp_is_empty, rsp_status
//   csr_      in         csr_valid & csr_ready  csr_order_mode
//
// Peek, rejected commands and a pop that empties the queue go straight to the
// response. A push climbs and a pop sinks through the heap level by level, at
// most log2 of CAPACITY levels, each a memory read then a compare and write.
// Synchronous reset empties the queue and selects max order; no memory sweep.
// Each result beat is shown for one cycle; the receiver cannot stall it.
module heap_priority_queue
   import hpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_root_value,
   output logic [COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_order_mode
);

   hpq_cmd_type  cmd;
   hpq_stat_type stat;

   hpq_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .stat        (stat),
      .cmd         (cmd)
   );

   hpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_value       (req_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_order_mode  (csr_order_mode),
      .rsp_valid       (rsp_valid),
      .rsp_root_value  (rsp_root_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== test/heap_priority_queue_tb.sv =====
// Self-checking bench for heap_priority_queue: push, pop and peek traffic in both heap orders,
// checked beat by beat against a heap model kept inside the bench.
// Depends on hpq_pkg and the heap_priority_queue design files.
module heap_priority_queue_tb;
   import hpq_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [DATA_W-1:0] root_value;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic                     is_empty;
      logic [1:0]               status;
   } heap_answer_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_command;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_root_value;
   logic [COUNT_OUT_W-1:0]   rsp_entry_count;
   logic                     rsp_is_empty;
   logic [1:0]               rsp_status;
   logic                     csr_valid;
   logic                     csr_ready;
   logic                     csr_order_mode;

   logic signed [DATA_W-1:0] heap_copy [CAPACITY];
   int unsigned              heap_fill;
   logic                     min_order;
   heap_answer_type          answers_due [$];
   logic signed [DATA_W-1:0] last_value;
   int                       idle_pct;
   int                       mismatch_count;
   int                       beats_sent;
   int                       beats_checked;
   int                       full_drops;
   int                       empty_hits;
   int unsigned              cycle_count;

   heap_priority_queue u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_root_value  (rsp_root_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_order_mode  (csr_order_mode)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("heap_priority_queue test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic bit outranks(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
      return min_order ? (a < b) : (a > b);
   endfunction

   task automatic swap_entries(input int unsigned i, input int unsigned j);
      logic signed [DATA_W-1:0] held;
      held = heap_copy[i];
      heap_copy[i] = heap_copy[j];
      heap_copy[j] = held;
   endtask

   task automatic apply_heap_command(input logic [1:0] cmd,
                                     input logic signed [DATA_W-1:0] val);
      heap_answer_type ans;
      int unsigned  pos;
      int unsigned  up;
      int unsigned  left;
      int unsigned  right;
      int unsigned  best;
      ans.status = STATUS_OK;
      if (cmd == CMD_PUSH) begin
         if (heap_fill >= CAPACITY) begin
            ans.status = STATUS_FULL;
            full_drops++;
         end else begin
            heap_copy[heap_fill] = val;
            heap_fill++;
            pos = heap_fill - 1;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!outranks(heap_copy[pos], heap_copy[up]))
                  break;
               swap_entries(pos, up);
               pos = up;
            end
         end
      end else if (cmd == CMD_POP) begin
         if (heap_fill == 0) begin
            ans.status = STATUS_EMPTY;
         end else begin
            heap_fill--;
            heap_copy[0] = heap_copy[heap_fill];
            pos = 0;
            forever begin
               left = 2 * pos + 1;
               right = 2 * pos + 2;
               best = pos;
               if (left < heap_fill && outranks(heap_copy[left], heap_copy[best]))
                  best = left;
               if (right < heap_fill && outranks(heap_copy[right], heap_copy[best]))
                  best = right;
               if (best == pos)
                  break;
               swap_entries(pos, best);
               pos = best;
            end
         end
      end else if (heap_fill == 0) begin
         ans.status = STATUS_EMPTY;
      end
      if (ans.status == STATUS_EMPTY)
         empty_hits++;
      ans.root_value = (heap_fill == 0) ? EMPTY_ROOT : heap_copy[0];
      ans.entry_count = COUNT_OUT_W'(heap_fill);
      ans.is_empty = (heap_fill == 0);
      answers_due = {answers_due, ans};
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = $urandom;
         3:       v = $signed(DATA_W'($urandom_range(0, 16))) - 8;
         4:       v = VALUE_MAX - $urandom_range(0, 3);
         5:       v = VALUE_MIN + $urandom_range(0, 3);
         6:       v = last_value;
         default: v = $signed($urandom) >>> $urandom_range(0, 31);
      endcase
      last_value = v;
      return v;
   endfunction

   task automatic send_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(1, 100) <= idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_command = cmd;
      req_value = val;
      do @(posedge clock); while (busy);
      apply_heap_command(cmd, val);
      beats_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (answers_due.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(input logic mode);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_order_mode = mode;
      do @(posedge clock); while (!csr_ready);
      min_order = mode;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin : check_beat
      heap_answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result beat with no command outstanding");
         end else begin
            want = answers_due.pop_front();
            beats_checked++;
            if (rsp_root_value !== want.root_value)
               report_mismatch($sformatf("root_value got %0d want %0d",
                                         rsp_root_value, want.root_value));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         rsp_entry_count, want.entry_count));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty got %b want %b",
                                         rsp_is_empty, want.is_empty));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_status, want.status));
         end
      end
   end

   task automatic test_empty_queue();
      send_command(CMD_PEEK, 0);
      send_command(CMD_POP, VALUE_MAX);
      send_command(CMD_SPARE, VALUE_MIN);
   endtask

   task automatic test_extreme_values();
      send_command(CMD_PUSH, VALUE_MAX);
      send_command(CMD_PUSH, VALUE_MIN);
      send_command(CMD_PUSH, 0);
      send_command(CMD_PUSH, -1);
      send_command(CMD_PUSH, 1);
      send_command(CMD_SPARE, -1);
      repeat (5) send_command(CMD_POP, VALUE_MIN);
      send_command(CMD_POP, 0);
   endtask

   task automatic test_order_switch();
      wait_idle();
      write_order(1'b1);
      send_command(CMD_PUSH, 5);
      send_command(CMD_PUSH, -3);
      send_command(CMD_PUSH, 7);
      send_command(CMD_PUSH, -3);
      send_command(CMD_PEEK, VALUE_MAX);
      // flip the order with four entries held
      wait_idle();
      write_order(1'b0);
      send_command(CMD_PUSH, 2);
      repeat (5) send_command(CMD_POP, 0);
      send_command(CMD_POP, 0);
   endtask

   task automatic test_full_queue(input logic mode);
      wait_idle();
      write_order(mode);
      while (heap_fill < CAPACITY)
         send_command(CMD_PUSH, pick_value());
      repeat (3) send_command(CMD_PUSH, pick_value());
      send_command(CMD_PEEK, pick_value());
      while (heap_fill > 0)
         send_command(($urandom_range(0, 7) == 0) ? CMD_PEEK : CMD_POP, pick_value());
   endtask

   task automatic test_random_mix(input int count);
      bit         filling;
      int         choice;
      logic [1:0] cmd;
      wait_idle();
      write_order(1'($urandom_range(0, 1)));
      filling = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            wait_idle();
            write_order(~min_order);
         end
         if (heap_fill == CAPACITY && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if (heap_fill == 0)
            filling = 1'b1;
         else if ($urandom_range(0, 59) == 0)
            filling = ~filling;
         choice = $urandom_range(0, 99);
         if (choice < 5)
            cmd = $urandom_range(0, 1) ? CMD_PEEK : CMD_SPARE;
         else if (choice < (filling ? 85 : 30))
            cmd = CMD_PUSH;
         else
            cmd = CMD_POP;
         send_command(cmd, pick_value());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_PUSH;
      req_value = '0;
      csr_valid = 1'b0;
      csr_order_mode = 1'b0;
      min_order = 1'b0;
      heap_fill = 0;
      last_value = '0;
      idle_pct = 29;
      mismatch_count = 0;
      beats_sent = 0;
      beats_checked = 0;
      full_drops = 0;
      empty_hits = 0;
      cycle_count = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_extreme_values();
      test_order_switch();
      test_full_queue(1'b1);
      test_random_mix(120);

      idle_pct = 63;
      test_random_mix(150);

      idle_pct = 0;
      test_full_queue(1'b0);
      test_random_mix(100);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d commands, checked %0d results: %0d pushes into a full queue,",
               beats_sent, beats_checked, full_drops);
      $display("%0d commands on an empty queue, both orders, order flipped with entries held.",
               empty_hits);
      if (mismatch_count == 0 && answers_due.size() == 0)
         $display("heap_priority_queue test passed");
      else
         $display("heap_priority_queue test failed");
      $finish;
   end

endmodule
